@@ sv/lsbpx_pkg.sv @@
// Package with the word types and constants of the LSB pixel payload extractor.
package lsbpx_pkg;

   typedef struct packed {
      logic [11:0] column;
      logic [11:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        frame_end;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [1:0]  part;
      logic [1:0]  status;
      logic [23:0] byte_total;
      logic        last;
   } rsp_word_type;

   localparam int unsigned MaxDimension       = 4096;
   localparam int unsigned PayloadFirstColumn = 4;

   localparam logic [7:0]  AsciiSlash = 8'h2F;
   localparam logic [7:0]  AsciiColon = 8'h3A;
   localparam logic [7:0]  AsciiZero  = 8'h30;
   localparam logic [7:0]  AsciiNine  = 8'h39;
   localparam logic [23:0] CountMax   = 24'hFFFFFF;

   localparam logic KindPayload = 1'b0;
   localparam logic KindStatus  = 1'b1;

   localparam logic [1:0] PartText      = 2'd0;
   localparam logic [1:0] PartSeparator = 2'd1;
   localparam logic [1:0] PartExtension = 2'd2;

   localparam logic [1:0] StatusOk           = 2'd0;
   localparam logic [1:0] StatusNoMarker     = 2'd1;
   localparam logic [1:0] StatusBadCount     = 2'd2;
   localparam logic [1:0] StatusUnterminated = 2'd3;

   localparam logic       RegPackLevel     = 1'b0;
   localparam logic [3:0] PackLevelReset   = 4'd3;

endpackage

@@ sv/lsb_pixel_payload_extractor.sv @@
// LSB pixel payload extractor: decodes a hidden marker, byte count and payload from pixels.
// An accepted word waits in the stage-1 register, is decoded into the result queue when that
// stage advances, and is then offered on rsp from the head of the queue.
// Throughput: one pixel per cycle, set by the single decode stage; a frame-end pixel that
// also emits a payload byte puts two words into the four-entry result queue, and the input
// stalls while that queue holds more than two words.
// Reset is synchronous and active high; it clears the frame state, the queue and sets
// pack_level to 3.
module lsb_pixel_payload_extractor (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lsbpx_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lsbpx_pkg::rsp_word_type rsp_word,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import lsbpx_pkg::*;

   typedef enum logic [1:0] {PH_MARKER, PH_COUNT, PH_PAYLOAD, PH_DONE} phase_type;

   localparam int RspDepth = 4;

   logic         s1_valid_ff;
   req_word_type s1_word_ff;
   logic [3:0]   pack_level_ff;

   phase_type    phase_ff, phase_in;
   logic [23:0]  declared_ff, declared_in;
   logic         digits_ff, digits_in;
   logic [23:0]  emitted_ff, emitted_in;
   logic         separator_ff, separator_in;
   logic [1:0]   error_ff, error_in;

   rsp_word_type fifo_ff [RspDepth];
   logic [1:0]   rd_ptr_ff, wr_ptr_ff;
   logic [2:0]   count_ff;

   logic         s1_advance;
   logic         pop;
   logic         in_range;
   logic [7:0]   pixel_byte;
   logic [3:0]   digit;
   logic [27:0]  next_count;
   logic         emit;
   logic [1:0]   part;
   logic [1:0]   end_status;
   logic [1:0]   push_n;
   rsp_word_type payload_word;
   rsp_word_type status_word;

   function automatic logic [7:0] extract_byte(input logic [3:0] level, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b);
      logic [7:0] v;
      case (level)
         4'd1: v = {5'b0, b[0], g[0], r[0]};
         4'd2: v = {2'b0, b[1:0], g[1:0], r[1:0]};
         4'd4: v = {g[3:0], r[3:0]};
         4'd5: v = {g[2:0], r[4:0]};
         4'd6: v = {g[1:0], r[5:0]};
         4'd7: v = {g[0], r[6:0]};
         4'd8: v = r;
         4'd9: v = r;
         default: v = {b[1:0], g[2:0], r[2:0]};
      endcase
      return v;
   endfunction

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == RegPackLevel) ? {28'b0, pack_level_ff} : 32'b0;

   assign pop        = rsp_valid && rsp_ready;
   assign s1_advance = s1_valid_ff && (count_ff <= 3'(RspDepth - 2));
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign rsp_valid  = (count_ff != 3'b0);
   assign rsp_word   = fifo_ff[rd_ptr_ff];

   always_comb begin
      pixel_byte = extract_byte(pack_level_ff, s1_word_ff.red, s1_word_ff.green,
                                s1_word_ff.blue);
      in_range = (32'(s1_word_ff.column) < MaxDimension) &&
                 (32'(s1_word_ff.row) < MaxDimension);
      digit = 4'(pixel_byte - AsciiZero);
      next_count = {1'b0, declared_ff, 3'b0} + {3'b0, declared_ff, 1'b0} + {24'b0, digit};

      phase_in     = phase_ff;
      declared_in  = declared_ff;
      digits_in    = digits_ff;
      emitted_in   = emitted_ff;
      separator_in = separator_ff;
      error_in     = error_ff;
      emit         = 1'b0;
      part         = PartText;

      if (in_range) begin
         case (phase_ff)
            PH_MARKER: begin
               if (s1_word_ff.column == 12'b0 && s1_word_ff.row == 12'b0 &&
                   pixel_byte == AsciiSlash) begin
                  phase_in = PH_COUNT;
               end else begin
                  phase_in = PH_DONE;
                  error_in = StatusNoMarker;
               end
            end
            PH_COUNT: begin
               if (s1_word_ff.column != 12'b0) begin
                  phase_in = PH_DONE;
                  error_in = StatusUnterminated;
               end else if (pixel_byte == AsciiColon) begin
                  if (digits_ff) begin
                     phase_in = PH_PAYLOAD;
                  end else begin
                     phase_in = PH_DONE;
                     error_in = StatusBadCount;
                  end
               end else if (pixel_byte >= AsciiZero && pixel_byte <= AsciiNine) begin
                  if (next_count[27:24] != 4'b0) begin
                     declared_in = CountMax;
                     phase_in    = PH_DONE;
                     error_in    = StatusBadCount;
                  end else begin
                     declared_in = next_count[23:0];
                     digits_in   = 1'b1;
                  end
               end else begin
                  phase_in = PH_DONE;
                  error_in = StatusBadCount;
               end
            end
            PH_PAYLOAD: begin
               if (32'(s1_word_ff.column) >= PayloadFirstColumn && emitted_ff < declared_ff) begin
                  emit = 1'b1;
                  if (separator_ff) begin
                     part = PartExtension;
                  end else if (pixel_byte == 8'b0) begin
                     part         = PartSeparator;
                     separator_in = 1'b1;
                  end else begin
                     part = PartText;
                  end
                  emitted_in = emitted_ff + 24'd1;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      if (phase_in == PH_MARKER) begin
         end_status = StatusNoMarker;
      end else if (phase_in == PH_COUNT) begin
         end_status = StatusUnterminated;
      end else begin
         end_status = error_in;
      end

      payload_word.kind         = KindPayload;
      payload_word.payload_byte = pixel_byte;
      payload_word.part         = part;
      payload_word.status       = StatusOk;
      payload_word.byte_total   = 24'b0;
      payload_word.last         = 1'b0;

      status_word.kind         = KindStatus;
      status_word.payload_byte = 8'b0;
      status_word.part         = PartText;
      status_word.status       = end_status;
      status_word.byte_total   = emitted_in;
      status_word.last         = 1'b1;

      push_n = {1'b0, emit} + {1'b0, s1_word_ff.frame_end};

      if (s1_word_ff.frame_end) begin
         phase_in     = PH_MARKER;
         declared_in  = 24'b0;
         digits_in    = 1'b0;
         emitted_in   = 24'b0;
         separator_in = 1'b0;
         error_in     = StatusOk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         pack_level_ff <= PackLevelReset;
         phase_ff      <= PH_MARKER;
         declared_ff   <= 24'b0;
         digits_ff     <= 1'b0;
         emitted_ff    <= 24'b0;
         separator_ff  <= 1'b0;
         error_ff      <= StatusOk;
         rd_ptr_ff     <= 2'b0;
         wr_ptr_ff     <= 2'b0;
         count_ff      <= 3'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == RegPackLevel) begin
            pack_level_ff <= csr_pwdata[3:0];
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_advance) begin
            phase_ff     <= phase_in;
            declared_ff  <= declared_in;
            digits_ff    <= digits_in;
            emitted_ff   <= emitted_in;
            separator_ff <= separator_in;
            error_ff     <= error_in;
            wr_ptr_ff    <= wr_ptr_ff + push_n;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + (s1_advance ? 3'(push_n) : 3'b0) - 3'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_word_ff <= req_word;
      end
      if (s1_advance) begin
         if (emit) begin
            fifo_ff[wr_ptr_ff] <= payload_word;
         end
         if (s1_word_ff.frame_end) begin
            fifo_ff[wr_ptr_ff + 2'(emit)] <= status_word;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= 3'(RspDepth))
      else $error("Result queue holds more words than its depth.");

   assert property (@(posedge clock) disable iff (reset) emitted_ff <= declared_ff)
      else $error("More payload bytes emitted than the declared count.");

   assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_word_ff.frame_end |=> phase_ff == PH_MARKER && emitted_ff == 24'b0)
      else $error("Frame state was not cleared after the frame-end pixel.");

endmodule

@@ sim/lsb_pixel_payload_extractor_tb.sv @@
// Self-checking testbench that streams pixel frames into the payload extractor.
module lsb_pixel_payload_extractor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsbpx_pkg::*;

   typedef enum logic [1:0] {
      PhMarker,
      PhCount,
      PhPayload,
      PhDone
   } frame_phase_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];

   logic [3:0]      pack_level_shadow = PackLevelReset;
   frame_phase_type frame_phase = PhMarker;
   logic [23:0]     declared_count = '0;
   bit              digits_seen = 1'b0;
   logic [23:0]     emitted_count = '0;
   bit              separator_seen = 1'b0;
   logic [1:0]      frame_status = StatusOk;

   bit          req_taken = 1'b0;
   bit          idling_on = 1'b1;
   int unsigned req_gap = 0;
   int unsigned hold_cycles = 0;
   int unsigned holds_requested = 0;
   int unsigned holds_granted = 0;
   int unsigned pixels_queued = 0;
   int unsigned frames_queued = 0;
   int unsigned words_checked = 0;
   int unsigned level_writes = 0;
   int unsigned error_count = 0;

   lsb_pixel_payload_extractor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic int unsigned channel_bits(input logic [3:0] level);
      if (level == 4'd0 || level > 4'd9) return PackLevelReset;
      if (level >= 4'd8) return 8;
      return level;
   endfunction

   function automatic logic [7:0] decode_pixel(input req_word_type w);
      int unsigned k;
      logic [7:0]  mask;
      logic [31:0] v;
      k = channel_bits(pack_level_shadow);
      mask = (k >= 8) ? 8'hFF : 8'((1 << k) - 1);
      v = 32'(w.red & mask) | (32'(w.green & mask) << k) | (32'(w.blue & mask) << (2 * k));
      return v[7:0];
   endfunction

   function automatic void abort_frame(input logic [1:0] code);
      frame_status = code;
      frame_phase = PhDone;
   endfunction

   function automatic void expect_word(input rsp_word_type r);
      expected_words.insert(expected_words.size(), r);
   endfunction

   function automatic void predict_pixel(input req_word_type w);
      logic [7:0]   b;
      logic [31:0]  next_count;
      logic [1:0]   st;
      rsp_word_type r;
      b = decode_pixel(w);
      if (w.column < MaxDimension && w.row < MaxDimension) begin
         case (frame_phase)
            PhMarker: begin
               if (w.column == 0 && w.row == 0 && b == AsciiSlash) frame_phase = PhCount;
               else abort_frame(StatusNoMarker);
            end
            PhCount: begin
               if (w.column != 0) begin
                  abort_frame(StatusUnterminated);
               end else if (b == AsciiColon) begin
                  if (digits_seen) frame_phase = PhPayload;
                  else abort_frame(StatusBadCount);
               end else if (b >= AsciiZero && b <= AsciiNine) begin
                  next_count = 32'(declared_count) * 10 + 32'(b - AsciiZero);
                  if (next_count > 32'(CountMax)) begin
                     declared_count = CountMax;
                     abort_frame(StatusBadCount);
                  end else begin
                     declared_count = next_count[23:0];
                     digits_seen = 1'b1;
                  end
               end else begin
                  abort_frame(StatusBadCount);
               end
            end
            PhPayload: begin
               if (w.column >= PayloadFirstColumn && emitted_count < declared_count) begin
                  r = '0;
                  r.kind = KindPayload;
                  r.payload_byte = b;
                  if (separator_seen) begin
                     r.part = PartExtension;
                  end else if (b == 8'h00) begin
                     r.part = PartSeparator;
                     separator_seen = 1'b1;
                  end else begin
                     r.part = PartText;
                  end
                  expect_word(r);
                  emitted_count = emitted_count + 24'd1;
               end
            end
            default: ;
         endcase
      end
      if (w.frame_end) begin
         st = frame_status;
         if (frame_phase == PhMarker) st = StatusNoMarker;
         else if (frame_phase == PhCount) st = StatusUnterminated;
         r = '0;
         r.kind = KindStatus;
         r.status = st;
         r.byte_total = emitted_count;
         r.last = 1'b1;
         expect_word(r);
         frame_phase = PhMarker;
         declared_count = '0;
         digits_seen = 1'b0;
         emitted_count = '0;
         separator_seen = 1'b0;
         frame_status = StatusOk;
      end
   endfunction

   // The chosen byte goes into the low bits of each channel; the upper bits are random.
   function automatic void push_pixel(input logic [11:0] col, input logic [11:0] row,
                                      input logic [7:0] value, input bit fe);
      req_word_type w;
      int unsigned  k;
      logic [7:0]   mask;
      k = channel_bits(pack_level_shadow);
      mask = (k >= 8) ? 8'hFF : 8'((1 << k) - 1);
      w.column = col;
      w.row = row;
      w.frame_end = fe;
      w.red   = (8'($urandom) & ~mask) | (value & mask);
      w.green = (8'($urandom) & ~mask) | (8'(value >> k) & mask);
      w.blue  = (8'($urandom) & ~mask) | (8'(value >> (2 * k)) & mask);
      pending_words.insert(pending_words.size(), w);
      pixels_queued++;
      if (fe) frames_queued++;
   endfunction

   task automatic queue_random_frame();
      int unsigned choice;
      int unsigned count_value;
      int unsigned pixel_total;
      int unsigned row_index;
      int unsigned i;
      string       digits;
      logic [7:0]  b;
      choice = $urandom_range(0, 99);
      if (choice >= 90) begin
         pixel_total = $urandom_range(1, 8);
         for (i = 0; i < pixel_total; i++)
            push_pixel(12'($urandom), 12'($urandom), 8'($urandom), i == pixel_total - 1);
         return;
      end
      count_value = $urandom_range(0, 12);
      if (choice < 3) count_value = 32'(CountMax);
      else if (choice < 6) count_value = 32'(CountMax) + $urandom_range(1, 1000000);
      digits = (choice == 82 || choice == 83) ? "" : $sformatf("%0d", count_value);
      if (choice == 88) push_pixel(0, 0, 8'(AsciiSlash + $urandom_range(1, 200)), 1'b0);
      else if (choice == 89)
         push_pixel(12'($urandom_range(1, 4095)), 12'($urandom), AsciiSlash, 1'b0);
      else push_pixel(0, 0, AsciiSlash, 1'b0);
      for (i = 0; i < digits.len(); i++)
         push_pixel(0, 12'(i + 1), digits[i],
                    (choice == 86 || choice == 87) && i == digits.len() - 1);
      if (choice == 86 || choice == 87) return;
      row_index = digits.len() + 1;
      if (choice == 80 || choice == 81) begin
         do b = 8'($urandom); while ((b >= AsciiZero && b <= AsciiNine) || b == AsciiColon);
         push_pixel(0, 12'(row_index), b, 1'b0);
         row_index++;
      end
      if (choice == 84 || choice == 85)
         push_pixel(12'($urandom_range(1, 3)), 0, AsciiColon, 1'b0);
      else push_pixel(0, 12'(row_index), AsciiColon, 1'b0);
      pixel_total = $urandom_range(0, 2);
      for (i = 0; i < pixel_total; i++)
         push_pixel(12'($urandom_range(0, PayloadFirstColumn - 1)), 12'(i), 8'($urandom),
                    1'b0);
      pixel_total = (count_value > 12 ? 12 : count_value) + $urandom_range(0, 3);
      if (pixel_total == 0) begin
         push_pixel(1, 0, 8'($urandom), 1'b1);
         return;
      end
      for (i = 0; i < pixel_total; i++) begin
         b = ($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom);
         if ($urandom_range(0, 9) == 0)
            push_pixel(12'($urandom_range(PayloadFirstColumn, 4095)), 12'($urandom), b,
                       i == pixel_total - 1);
         else
            push_pixel(12'(PayloadFirstColumn + i / 4), 12'(i % 4), b,
                       i == pixel_total - 1);
      end
   endtask

   task automatic write_pack_level(input logic [3:0] level);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * RegPackLevel);
      csr_pwdata <= 32'(level);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      pack_level_shadow = level;
      level_writes++;
   endtask

   task automatic wait_for_drain();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   always @(negedge clock) begin : word_driver
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 15);
            req_valid <= 1'b0;
         end else begin
            req_word <= pending_words.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin : ready_driver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles != 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (holds_granted != holds_requested) begin
         holds_granted++;
         hold_cycles = 299;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         hold_cycles = $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : scoreboard
      rsp_word_type want;
      req_taken = req_valid && req_ready;
      if (!reset) begin
         if (req_taken) predict_pixel(req_word);
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result word kind=%0d byte=%02h status=%0d",
                           $time, rsp_word.kind, rsp_word.payload_byte, rsp_word.status);
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.kind !== want.kind || rsp_word.payload_byte !== want.payload_byte ||
                   rsp_word.part !== want.part || rsp_word.status !== want.status ||
                   rsp_word.byte_total !== want.byte_total || rsp_word.last !== want.last) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t: result mismatch, expected kind=%0d byte=%02h part=%0d",
                              $time, want.kind, want.payload_byte, want.part,
                              " status=%0d total=%0d last=%0d",
                              want.status, want.byte_total, want.last);
                     $display("%0t:                  actual kind=%0d byte=%02h part=%0d",
                              $time, rsp_word.kind, rsp_word.payload_byte, rsp_word.part,
                              " status=%0d total=%0d last=%0d",
                              rsp_word.status, rsp_word.byte_total, rsp_word.last);
                  end
               end
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned phase_level [0:10] = '{1, 2, 8, 0, 15, 3, 4, 5, 6, 7, 9};
      int unsigned phase_start;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_pack_level(4'd9);

      push_pixel(0, 0, AsciiSlash, 1'b0);
      push_pixel(0, 1, "3", 1'b0);
      push_pixel(0, 2, AsciiColon, 1'b0);
      push_pixel(1, 0, 8'hAA, 1'b0);
      push_pixel(4, 0, 8'hFF, 1'b0);
      push_pixel(4, 1, 8'h00, 1'b0);
      push_pixel(4095, 4095, 8'h00, 1'b1);
      push_pixel(0, 0, AsciiSlash, 1'b0);
      push_pixel(0, 1, AsciiZero, 1'b0);
      push_pixel(0, 2, AsciiColon, 1'b0);
      push_pixel(4, 0, 8'h55, 1'b1);
      push_pixel(0, 0, "x", 1'b1);
      push_pixel(0, 1, AsciiSlash, 1'b0);
      push_pixel(0, 2, "1", 1'b1);
      push_pixel(0, 0, AsciiSlash, 1'b0);
      push_pixel(0, 1, AsciiColon, 1'b0);
      push_pixel(4, 0, 8'h41, 1'b1);
      push_pixel(0, 0, AsciiSlash, 1'b0);
      push_pixel(0, 1, "1", 1'b0);
      push_pixel(0, 2, "a", 1'b0);
      push_pixel(0, 3, AsciiNine, 1'b1);
      push_pixel(0, 0, AsciiSlash, 1'b0);
      push_pixel(0, 1, "5", 1'b0);
      push_pixel(1, 0, "2", 1'b1);
      push_pixel(0, 0, AsciiSlash, 1'b0);
      push_pixel(0, 1, "5", 1'b1);
      wait_for_drain();

      for (int p = 0; p < 11; p++) begin
         write_pack_level(4'(phase_level[p]));
         idling_on = (p != 10);
         if (p == 3) holds_requested++;
         phase_start = pixels_queued;
         while (pixels_queued - phase_start < 48) queue_random_frame();
         wait_for_drain();
      end

      if (expected_words.size() != 0) error_count++;
      $display("Sent %0d pixels in %0d frames over %0d pack level writes, %0d words checked.",
               pixels_queued, frames_queued, level_writes, words_checked);
      $display("Frames included good payloads, separators, marker and count errors, and stalls.");
      if (error_count == 0) begin
         $display("[lsb_pixel_payload_extractor] OK");
      end else begin
         $display("%0d mismatches in total.", error_count);
         $display("[lsb_pixel_payload_extractor] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(2_000_000);
      $display("[lsb_pixel_payload_extractor] ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/lsbpx_pkg.sv
sv/lsb_pixel_payload_extractor.sv
sim/lsb_pixel_payload_extractor_tb.sv
